### src/ced_pkg.sv
// Shared constants and types for the cascaded exponential damper.
// No dependencies; imported by ced_mul, ced_div and the top level.
`default_nettype none
package ced_pkg;
	localparam int MUL_W     = 36;             // serial multiplier operand width
	localparam int MUL_DIG   = 4;              // bits of b consumed per cycle
	localparam int MUL_STEPS = MUL_W / MUL_DIG;
	localparam int DIV_QW    = 20;             // quotient bits of the serial divider

	localparam logic [32:0] SETTLE_LIMIT = 33'd66;  // 0.001 in Q16.16, rounded up

	typedef logic [MUL_W-1:0]   mul_op_t;
	typedef logic [2*MUL_W-1:0] mul_prod_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_DEST = 2'd2,
		CMD_RSVD = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_TAU    = 2'd0,
		REG_ORDER  = 2'd1,
		REG_TARGET = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;
endpackage
`default_nettype wire

### src/ced_mul.sv
// Digit-serial unsigned multiplier, MUL_DIG bits of b per cycle.
// Depends on ced_pkg.
`default_nettype none
module ced_mul (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  ced_pkg::mul_op_t    a,
	input  ced_pkg::mul_op_t    b,
	output logic                done,
	output ced_pkg::mul_prod_t  p
);
	import ced_pkg::*;

	localparam int CW = $clog2(MUL_STEPS);

	mul_op_t        a_q, b_q;
	mul_prod_t      p_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q, done_q;
	logic [MUL_W+4:0]       part, sum;
	logic [2*MUL_W+4:0]     wide;

	always_comb begin
		part = {5'd0, a_q} * {{(MUL_W+1){1'b0}}, b_q[MUL_DIG-1:0]};
		sum  = {5'd0, p_q[2*MUL_W-1:MUL_W]} + part;
		wide = {sum, p_q[MUL_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_STEPS-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (run_q) begin
			b_q <= b_q >> MUL_DIG;
			p_q <= wide[2*MUL_W+MUL_DIG-1:MUL_DIG];
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule
`default_nettype wire

### src/ced_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ced_pkg; remainder must start below the divisor.
`default_nettype none
module ced_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [31:0]                   rem_init,
	input  wire [ced_pkg::DIV_QW-1:0]    num,
	input  wire [31:0]                   divisor,
	output logic                         done,
	output logic [ced_pkg::DIV_QW-1:0]   quo
);
	import ced_pkg::*;

	localparam int CW = $clog2(DIV_QW);

	logic [31:0]        rem_q, div_q;
	logic [DIV_QW-1:0]  num_q, quo_q;
	logic [CW-1:0]      cnt_q;
	logic               run_q, done_q;
	logic [32:0]        rem2, diff;
	logic               ge;

	always_comb begin
		rem2 = {rem_q, num_q[DIV_QW-1]};
		diff = rem2 - {1'b0, div_q};
		ge   = rem2 >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_QW-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			div_q <= divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : rem2[31:0];
			num_q <= {num_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### src/cascaded_exponential_damper.sv
// Top level: cascaded exponential damper with shared serial multiplier and divider.
// Depends on ced_pkg, ced_mul, ced_div.
//
//  channel  | direction | contents
//  s_*      | in        | tuser: cmd; tdata: value_in, time_stamp
//  m_*      | out       | tuser: settled; tdata: value_out
//  cfg_*    | in        | register write: tau, filter order, initial target
//
// One item at a time: a check, two divides, ten products and one product per stage,
// then the output, from accept to next accept; zero tau or elapsed at or above 16 tau
// skips the alpha math. A first item (no tick recorded yet) only records its time
// stamp and gives no result. A result waits in the output register; the next item
// is taken meanwhile and holds in its final state until the register frees. Reset
// is asynchronous.
`default_nettype none
module cascaded_exponential_damper #(
	parameter int MAX_STAGES = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [79:0] s_tdata,   // [31:0] value_in, [79:32] time_stamp
	input  wire  [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] value_out
	output logic [0:0]  m_tuser,   // [0] settled
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import ced_pkg::*;

	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CHK  = 9'b000000010,
		ST_DIVX = 9'b000000100,
		ST_MT2  = 9'b000001000,
		ST_MT3  = 9'b000010000,
		ST_DIV6 = 9'b000100000,
		ST_SQR  = 9'b001000000,
		ST_STL  = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t         state_q;
	logic [31:0]    tau_q;
	logic [2:0]     order_q;
	logic [31:0]    target_q;
	logic [47:0]    last_tick_q, now_q, elapsed_q;
	logic [31:0]    stage_q [MAX_STAGES];
	logic [27:0]    t_q;
	logic [23:0]    t2_q;
	logic [2:0]     sq_cnt_q;
	logic [16:0]    alpha_q;
	logic [IW-1:0]  idx_q;
	logic [31:0]    prev_q;
	logic [32:0]    dist_q;
	logic           neg_q, stg_busy_q;
	logic           m_valid_q;
	logic [31:0]    m_data_q;
	logic           m_settled_q;

	logic           mul_start_q, mul_done;
	mul_op_t        mul_a_q, mul_b_q;
	mul_prod_t      mul_p;
	logic           div_start_q, div_done;
	logic [31:0]    div_rem_q, div_den_q;
	logic [DIV_QW-1:0] div_num_q, div_quo;

	ced_mul u_mul (
		.clk, .arst_n, .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .p(mul_p)
	);

	ced_div u_div (
		.clk, .arst_n, .start(div_start_q), .rem_init(div_rem_q), .num(div_num_q),
		.divisor(div_den_q), .done(div_done), .quo(div_quo)
	);

	logic        accept;
	cmd_t        cmd;
	logic [31:0] val_in;
	logic [47:0] ts_in;
	logic        active;
	logic [32:0] diff, mag, r, nxt;
	logic [33:0] y34;
	logic [31:0] y_new;
	logic [32:0] a_round;
	logic [16:0] alpha_new;
	logic        out_free;

	always_comb begin
		cmd    = cmd_t'(s_tuser);
		val_in = s_tdata[31:0];
		ts_in  = s_tdata[79:32];
		accept = s_tvalid && s_tready;
		active = 4'(idx_q) < {1'b0, order_q};
		diff   = {stage_q[idx_q][31], stage_q[idx_q]} - {prev_q[31], prev_q};
		mag    = diff[32] ? (33'd0 - diff) : diff;
		r      = 33'(({15'd0, mul_p[48:0]} + 64'h8000) >> 16);
		nxt    = neg_q ? ({prev_q[31], prev_q} - r) : ({prev_q[31], prev_q} + r);
		y34    = 34'h1_0000_0000 - {6'd0, t_q} + {11'd0, t2_q[23:1]}
		         - {14'd0, div_quo};
		y_new  = mul_p[63:32];
		a_round = {1'b0, y_new} + 33'h8000;
		alpha_new = (a_round[32:16] > 17'h10000) ? 17'h10000 : a_round[32:16];
		out_free = !m_valid_q || m_tready;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_settled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tau_q       <= 32'd300000;
			order_q     <= 3'd3;
			target_q    <= '0;
			last_tick_q <= '0;
			for (int i = 0; i < MAX_STAGES; i++) begin
				stage_q[i] <= '0;
			end
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			m_valid_q   <= 1'b0;
			stg_busy_q  <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TAU:    tau_q <= cfg_data;
					REG_ORDER:  order_q <= cfg_data[2:0];
					REG_TARGET: target_q <= cfg_data;
					REG_NONE:   ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_LOAD) begin
							for (int i = 0; i < MAX_STAGES; i++) begin
								stage_q[i] <= val_in;
							end
						end else if (cmd == CMD_DEST) begin
							target_q <= val_in;
						end
						if (last_tick_q == '0) begin
							last_tick_q <= ts_in;
						end else begin
							now_q     <= ts_in;
							elapsed_q <= (ts_in >= last_tick_q) ? ts_in - last_tick_q : '0;
							state_q   <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (tau_q == '0 || elapsed_q >= {12'd0, tau_q, 4'd0}) begin
						alpha_q <= '0;
						idx_q   <= '0;
						prev_q  <= target_q;
						dist_q  <= '0;
						state_q <= ST_STL;
					end else begin
						div_rem_q   <= elapsed_q[35:4];
						div_num_q   <= {elapsed_q[3:0], 16'd0};
						div_den_q   <= tau_q;
						div_start_q <= 1'b1;
						state_q     <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						t_q         <= {div_quo, 8'd0};
						mul_a_q     <= MUL_W'({div_quo, 8'd0});
						mul_b_q     <= MUL_W'({div_quo, 8'd0});
						mul_start_q <= 1'b1;
						state_q     <= ST_MT2;
					end
				end
				ST_MT2: begin
					if (mul_done) begin
						t2_q        <= mul_p[55:32];
						mul_a_q     <= MUL_W'(mul_p[55:32]);
						mul_b_q     <= MUL_W'(t_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_MT3;
					end
				end
				ST_MT3: begin
					if (mul_done) begin
						div_rem_q   <= '0;
						div_num_q   <= mul_p[51:32];
						div_den_q   <= 32'd6;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV6;
					end
				end
				ST_DIV6: begin
					if (div_done) begin
						// cap y below one before the eight squarings
						mul_a_q     <= MUL_W'((y34[33:32] != 2'd0) ? 32'hFFFF_FFFF : y34[31:0]);
						mul_b_q     <= MUL_W'((y34[33:32] != 2'd0) ? 32'hFFFF_FFFF : y34[31:0]);
						mul_start_q <= 1'b1;
						sq_cnt_q    <= '0;
						state_q     <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						if (sq_cnt_q == 3'd7) begin
							alpha_q <= alpha_new;
							idx_q   <= '0;
							prev_q  <= target_q;
							dist_q  <= '0;
							state_q <= ST_STL;
						end else begin
							sq_cnt_q    <= sq_cnt_q + 1'b1;
							mul_a_q     <= MUL_W'(y_new);
							mul_b_q     <= MUL_W'(y_new);
							mul_start_q <= 1'b1;
						end
					end
				end
				ST_STL: begin
					// launch one stage product, then take it back in this state
					if (!stg_busy_q) begin
						neg_q       <= diff[32];
						mul_a_q     <= MUL_W'(mag);
						mul_b_q     <= MUL_W'(active ? alpha_q : 17'd0);
						mul_start_q <= 1'b1;
						stg_busy_q  <= 1'b1;
					end else if (mul_done) begin
						stg_busy_q     <= 1'b0;
						stage_q[idx_q] <= nxt[31:0];
						prev_q         <= nxt[31:0];
						if ((idx_q == '0 || active) && r > dist_q) begin
							dist_q <= r;
						end
						if (idx_q == IW'(MAX_STAGES-1)) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (dist_q < SETTLE_LIMIT) begin
							for (int i = 0; i < MAX_STAGES; i++) begin
								stage_q[i] <= target_q;
							end
							m_data_q    <= target_q;
							m_settled_q <= 1'b1;
						end else begin
							m_data_q    <= stage_q[MAX_STAGES-1];
							m_settled_q <= 1'b0;
							last_tick_q <= now_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
